// ===== src/fcgi_nv_pkg.sv =====
// ----------------------------------------------------------------------------
// fcgi_nv_pkg
// Shared types and constants for the name-value pair parser.
// ----------------------------------------------------------------------------
`default_nettype none

package fcgi_nv_pkg;

    localparam int LEN_W = 31;

    typedef enum logic [2:0] {
        PH_NAME_LEN   = 3'd0,
        PH_NAME_TAIL  = 3'd1,
        PH_VAL_LEN    = 3'd2,
        PH_VAL_TAIL   = 3'd3,
        PH_NAME_BYTES = 3'd4,
        PH_VAL_BYTES  = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        KIND_LEN   = 2'd0,
        KIND_NAME  = 2'd1,
        KIND_VALUE = 2'd2
    } kind_t;

    localparam logic [1:0] TAIL_BYTES = 2'd3;

    typedef struct packed {
        phase_t             phase;
        logic [LEN_W-1:0]   acc;
        logic [1:0]         left;
        logic [LEN_W-1:0]   name_len;
        logic [LEN_W-1:0]   value_len;
        logic [LEN_W-1:0]   remaining;
    } parse_state_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic [LEN_W-1:0]   name_length;
        logic [LEN_W-1:0]   value_length;
        logic               name_done;
        logic               pair_done;
        logic               truncated;
    } parse_result_t;

endpackage

`default_nettype wire

// ===== src/fcgi_nv_step.sv =====
// ----------------------------------------------------------------------------
// fcgi_nv_step
// Next-state and result logic for one content byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fcgi_nv_step (
    input  var fcgi_nv_pkg::parse_state_t  cur,
    input  wire logic [7:0]                data_byte,
    input  wire logic                      last_byte,
    output var fcgi_nv_pkg::parse_state_t  nxt,
    output var fcgi_nv_pkg::parse_result_t res
);

    fcgi_nv_pkg::parse_state_t s;
    logic [fcgi_nv_pkg::LEN_W-1:0] acc_shift;
    logic [fcgi_nv_pkg::LEN_W-1:0] first_len;
    logic [fcgi_nv_pkg::LEN_W-1:0] tail_len;
    logic [1:0]                    left_dec;
    logic                          tail_done;
    logic                          rem_last;
    logic [fcgi_nv_pkg::LEN_W-1:0] rem_dec;
    logic                          nd;
    logic                          pd;

    assign acc_shift = {cur.acc[fcgi_nv_pkg::LEN_W-9:0], data_byte};
    assign first_len = {{(fcgi_nv_pkg::LEN_W-7){1'b0}}, data_byte[6:0]};
    assign tail_len  = acc_shift;
    assign tail_done = (cur.left <= 2'd1);
    assign left_dec  = (cur.left != 2'd0) ? cur.left - 2'd1 : 2'd0;
    assign rem_last  = (cur.remaining <= {{(fcgi_nv_pkg::LEN_W-1){1'b0}}, 1'b1});
    assign rem_dec   = cur.remaining - {{(fcgi_nv_pkg::LEN_W-1){1'b0}}, 1'b1};

    always_comb
    begin
        s            = cur;
        nd           = 1'b0;
        pd           = 1'b0;
        res.kind     = fcgi_nv_pkg::KIND_LEN;
        res.out_byte = 8'd0;

        case (cur.phase)
            fcgi_nv_pkg::PH_NAME_TAIL:
            begin
                s.acc  = acc_shift;
                s.left = left_dec;
                if (tail_done)
                begin
                    s.name_len = tail_len;
                    s.phase    = fcgi_nv_pkg::PH_VAL_LEN;
                end
            end
            fcgi_nv_pkg::PH_VAL_LEN, fcgi_nv_pkg::PH_VAL_TAIL:
            begin
                if (cur.phase == fcgi_nv_pkg::PH_VAL_LEN)
                begin
                    if (data_byte[7])
                    begin
                        s.acc   = first_len;
                        s.left  = fcgi_nv_pkg::TAIL_BYTES;
                        s.phase = fcgi_nv_pkg::PH_VAL_TAIL;
                    end
                    else
                    begin
                        s.value_len = {{(fcgi_nv_pkg::LEN_W-8){1'b0}}, data_byte};
                    end
                end
                else
                begin
                    s.acc  = acc_shift;
                    s.left = left_dec;
                    if (tail_done)
                    begin
                        s.value_len = tail_len;
                    end
                end
                // both lengths known
                if ((cur.phase == fcgi_nv_pkg::PH_VAL_LEN && !data_byte[7])
                    || (cur.phase == fcgi_nv_pkg::PH_VAL_TAIL && tail_done))
                begin
                    if (s.name_len != '0)
                    begin
                        s.remaining = s.name_len;
                        s.phase     = fcgi_nv_pkg::PH_NAME_BYTES;
                    end
                    else
                    begin
                        nd = 1'b1;
                        if (s.value_len != '0)
                        begin
                            s.remaining = s.value_len;
                            s.phase     = fcgi_nv_pkg::PH_VAL_BYTES;
                        end
                        else
                        begin
                            pd      = 1'b1;
                            s.phase = fcgi_nv_pkg::PH_NAME_LEN;
                        end
                    end
                end
            end
            fcgi_nv_pkg::PH_NAME_BYTES:
            begin
                res.kind     = fcgi_nv_pkg::KIND_NAME;
                res.out_byte = data_byte;
                if (rem_last)
                begin
                    nd = 1'b1;
                    if (cur.value_len != '0)
                    begin
                        s.remaining = cur.value_len;
                        s.phase     = fcgi_nv_pkg::PH_VAL_BYTES;
                    end
                    else
                    begin
                        s.remaining = '0;
                        pd          = 1'b1;
                        s.phase     = fcgi_nv_pkg::PH_NAME_LEN;
                    end
                end
                else
                begin
                    s.remaining = rem_dec;
                end
            end
            fcgi_nv_pkg::PH_VAL_BYTES:
            begin
                res.kind     = fcgi_nv_pkg::KIND_VALUE;
                res.out_byte = data_byte;
                if (rem_last)
                begin
                    s.remaining = '0;
                    pd          = 1'b1;
                    s.phase     = fcgi_nv_pkg::PH_NAME_LEN;
                end
                else
                begin
                    s.remaining = rem_dec;
                end
            end
            default:
            begin
                // name length, also unused phase codes
                s.value_len = '0;
                if (data_byte[7])
                begin
                    s.name_len = '0;
                    s.acc      = first_len;
                    s.left     = fcgi_nv_pkg::TAIL_BYTES;
                    s.phase    = fcgi_nv_pkg::PH_NAME_TAIL;
                end
                else
                begin
                    s.name_len = {{(fcgi_nv_pkg::LEN_W-8){1'b0}}, data_byte};
                    s.phase    = fcgi_nv_pkg::PH_VAL_LEN;
                end
            end
        endcase

        res.name_length  = s.name_len;
        res.value_length = s.value_len;
        res.name_done    = nd;
        res.pair_done    = pd;
        res.truncated    = last_byte && (s.phase != fcgi_nv_pkg::PH_NAME_LEN);

        if (res.truncated)
        begin
            nxt = '{phase: fcgi_nv_pkg::PH_NAME_LEN, acc: '0, left: 2'd0,
                    name_len: '0, value_len: '0, remaining: '0};
        end
        else
        begin
            nxt = s;
        end
    end

endmodule

`default_nettype wire

// ===== src/fastcgi_name_value_parser_core.sv =====
// ----------------------------------------------------------------------------
// fastcgi_name_value_parser_core
// Decodes the name-value pairs of params record content, one byte per item.
// ----------------------------------------------------------------------------
// each accepted item's result is registered in the result entry, or in the skid
// entry while the result entry is held; one item per cycle while the skid is empty
// a two-entry output stage (result register plus skid) keeps s_tready high
// while only the result entry holds a waiting result
// reset: rst_n clears the parser state and the valid flags of both output entries
`default_nettype none

module fastcgi_name_value_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output var  logic        s_tready,
    input  wire logic [7:0]  s_tdata,   // data_byte
    input  wire logic        s_tlast,
    output var  logic        m_tvalid,
    input  wire logic        m_tready,
    output var  logic [79:0] m_tdata,   // out_byte, name_length, value_length,
                                        // name_done, pair_done, truncated, zero fill
    output var  logic [1:0]  m_tuser    // kind
);

    fcgi_nv_pkg::parse_state_t  state_reg;
    fcgi_nv_pkg::parse_state_t  state_next;
    fcgi_nv_pkg::parse_result_t res;
    fcgi_nv_pkg::parse_result_t out_reg;
    fcgi_nv_pkg::parse_result_t skid_reg;
    logic                       out_valid_reg;
    logic                       skid_valid_reg;
    logic                       accept;
    logic                       take;

    fcgi_nv_step u_step (
        .cur       (state_reg),
        .data_byte (s_tdata),
        .last_byte (s_tlast),
        .nxt       (state_next),
        .res       (res)
    );

    assign s_tready = !skid_valid_reg;
    assign accept   = s_tvalid && s_tready;
    assign take     = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{phase: fcgi_nv_pkg::PH_NAME_LEN, acc: '0, left: 2'd0,
                                name_len: '0, value_len: '0, remaining: '0};
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
                if (!out_valid_reg || take)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (take)
            begin
                if (skid_valid_reg)
                begin
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
        else if (take && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {7'd0, out_reg.truncated, out_reg.pair_done, out_reg.name_done,
                       out_reg.value_length, out_reg.name_length, out_reg.out_byte};

`ifndef NO_ASSERTIONS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without result entry");

    a_trunc_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && res.truncated) |=>
            (state_reg.phase == fcgi_nv_pkg::PH_NAME_LEN && state_reg.remaining == '0))
        else $error("parser not reset after truncation");

    a_pair_not_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_reg.pair_done && out_reg.truncated))
        else $error("pair done and truncated together");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != fcgi_nv_pkg::KIND_LEN) |-> !out_reg.truncated
            || out_reg.name_length != '0 || out_reg.value_length != '0)
        else $error("data byte result without decoded length");
`endif

endmodule

`default_nettype wire
